[src/fgrf_pkg.sv]
// fgrf_pkg: shared types and character codes for the FASTA N-gap run finder.
// No dependencies; used by every module of the block.
package fgrf_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned SEQ_W  = 16;

    localparam logic [CHAR_W-1:0] CH_GAP     = 8'h4E; // 'N'
    localparam logic [CHAR_W-1:0] CH_HEADER  = 8'h3E; // '>'
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A; // '\n'

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_ordinal;
        logic [POS_W-1:0] gap_start;
        logic [POS_W-1:0] gap_end;
    } t_out_beat;

endpackage

[src/fgrf_scan.sv]
// fgrf_scan: parser state (header flag, run flag, position, run start, header count)
// and the next-state / result logic for one beat. Depends on fgrf_pkg.
module fgrf_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  fgrf_pkg::t_in_beat  i_beat,
    output logic                o_res_valid,
    output fgrf_pkg::t_out_beat o_res
);

    logic                       r_in_header, n_in_header;
    logic                       r_in_gap, n_in_gap;
    logic [fgrf_pkg::POS_W-1:0] r_pos, n_pos;
    logic [fgrf_pkg::POS_W-1:0] r_gap_begin, n_gap_begin;
    logic [fgrf_pkg::SEQ_W-1:0] r_hdr_cnt, n_hdr_cnt;

    always_comb begin
        n_in_header = r_in_header;
        n_in_gap    = r_in_gap;
        n_pos       = r_pos;
        n_gap_begin = r_gap_begin;
        n_hdr_cnt   = r_hdr_cnt;
        o_res_valid = 1'b0;
        o_res       = '{seq_ordinal: r_hdr_cnt, gap_start: r_gap_begin, gap_end: r_pos};

        if (i_beat.end_of_stream) begin
            o_res_valid = r_in_gap;
            n_in_gap    = 1'b0;
        end else if (i_beat.char_code == fgrf_pkg::CH_HEADER) begin
            o_res_valid = r_in_gap;
            n_in_gap    = 1'b0;
            n_in_header = 1'b1;
            if (r_hdr_cnt != '1) begin
                n_hdr_cnt = r_hdr_cnt + 1'b1;
            end
            n_pos = '0;
        end else if (r_in_header) begin
            if (i_beat.char_code == fgrf_pkg::CH_NEWLINE) begin
                n_in_header = 1'b0;
                n_pos       = '0;
            end
        end else if (i_beat.char_code != fgrf_pkg::CH_NEWLINE) begin
            if (i_beat.char_code == fgrf_pkg::CH_GAP) begin
                if (!r_in_gap) begin
                    n_gap_begin = r_pos;
                    n_in_gap    = 1'b1;
                end
            end else begin
                o_res_valid = r_in_gap;
                n_in_gap    = 1'b0;
            end
            if (r_pos != '1) begin
                n_pos = r_pos + 1'b1;
            end
        end

        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header <= 1'b0;
            r_in_gap    <= 1'b0;
            r_pos       <= '0;
            r_gap_begin <= '0;
            r_hdr_cnt   <= '0;
        end else if (i_step) begin
            r_in_header <= n_in_header;
            r_in_gap    <= n_in_gap;
            r_pos       <= n_pos;
            r_gap_begin <= n_gap_begin;
            r_hdr_cnt   <= n_hdr_cnt;
        end
    end

endmodule

[src/fgrf_outq.sv]
// fgrf_outq: two-entry result queue that decouples the scanner from output stall.
// Depends on fgrf_pkg.
module fgrf_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fgrf_pkg::t_out_beat i_data,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output fgrf_pkg::t_out_beat o_data
);

    fgrf_pkg::t_out_beat r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/fasta_gap_run_finder_top.sv]
// fasta_gap_run_finder_top: top level of the FASTA N-gap run finder.
// Depends on fgrf_pkg, fgrf_scan and fgrf_outq.
//
// Takes one byte of FASTA text per beat and reports every maximal run of
// uppercase 'N' as one output beat {seq_ordinal, gap_start, gap_end}, end
// exclusive, positions zero-based per sequence. Header lines ('>' up to
// newline) are skipped and counted; newlines do not advance the position.
// An open run closes on a non-'N' base, on '>' or on an end_of_stream beat.
// Rate: one input beat per clock, sustained, as long as output is taken.
// A beat is parsed by the scanner while it sits in the input register; its
// result (if any) is written into the result queue once the queue has room,
// and the output shows the oldest entry of that queue. A two-entry result
// queue lets the input keep flowing while an output beat waits; o_stall
// rises only when that queue is full and the input register holds a beat,
// and drops the cycle after the receiver takes a result.
module fasta_gap_run_finder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  fgrf_pkg::t_in_beat  i_beat,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output fgrf_pkg::t_out_beat o_beat
);

    // input register
    logic               r_in_valid;
    fgrf_pkg::t_in_beat r_in_beat;

    logic                q_full;
    logic                step;
    logic                res_valid;
    fgrf_pkg::t_out_beat res;

    // registered beat moves into the scanner whenever the queue has room
    assign step    = r_in_valid && !q_full;
    assign o_stall = r_in_valid && q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_beat <= i_beat;
        end
    end

    fgrf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_beat      (r_in_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fgrf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_beat)
    );

endmodule

[src/fgrf_checker.sv]
// fgrf_checker: port-level assertions for fasta_gap_run_finder_top, plus its bind.
// Depends on fgrf_pkg.
module fgrf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input fgrf_pkg::t_in_beat  i_beat,
    input logic                o_valid,
    input logic                i_stall,
    input fgrf_pkg::t_out_beat o_beat
);

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_beat))
        else $error("result beat dropped or changed under stall");

    // input only backs up when a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // run never ends before it starts
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_beat.gap_start <= o_beat.gap_end)
        else $error("gap_end below gap_start");

    // cycle after a reset edge is open and empty
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall && !o_valid)
        else $error("state not cleared by reset");

endmodule

bind fasta_gap_run_finder_top fgrf_checker u_fgrf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_beat  (i_beat),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_beat  (o_beat)
);
